// ===== rtl/ers_pkg.sv =====
// Shared constants, types and the command format of the expression row splitter.
package ers_pkg;

   localparam int PENDING_WS_MAX = 32;
   localparam int CountWidth     = $clog2(PENDING_WS_MAX + 1);
   localparam int WsIdxWidth     = (PENDING_WS_MAX > 1) ? $clog2(PENDING_WS_MAX) : 1;

   localparam logic [CountWidth-1:0] WsMaxCount = CountWidth'(PENDING_WS_MAX);

   localparam int QueueDepth  = 4;
   localparam int QPtrWidth   = $clog2(QueueDepth);
   localparam int QCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CommentRst = 8'h23;

   // One classified request: held whitespace, an optional character and an
   // optional end-of-row marker, emitted by the back end in that order.
   typedef struct packed {
      logic [CountWidth-1:0]     ws_count;
      logic [PENDING_WS_MAX-1:0] ws_tabs;
      logic                      has_char;
      logic [7:0]                char_val;
      logic                      has_eor;
      logic                      ovf;
   } ers_cmd_type;

endpackage

// ===== rtl/ers_if.sv =====
// Handshake interfaces for the request and result channels.
interface ers_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_text;

   modport source (output valid, output char_in, output end_of_text, input ready);
   modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface ers_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       kind;
   logic       ws_overflow;
   logic       last;

   modport source (output valid, output out_char, output kind, output ws_overflow,
                   output last, input ready);
   modport sink (input valid, input out_char, input kind, input ws_overflow,
                 input last, output ready);
endinterface

// ===== rtl/ers_front.sv =====
// Front end: accepts text bytes, tracks row state and issues commands.
module ers_front import ers_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   ers_req_if.sink     req,
   input  logic        q_full,
   output logic        q_push,
   output ers_cmd_type q_cmd
);

   logic [7:0]                comment_char_ff;
   logic                      in_comment_ff, in_comment_in;
   logic                      rhc_ff, rhc_in;
   logic [CountWidth-1:0]     pending_count_ff, pending_count_in;
   logic [PENDING_WS_MAX-1:0] pending_tabs_ff, pending_tabs_in;
   logic                      overflow_seen_ff, overflow_seen_in;

   logic accept;
   logic is_break, is_cc, is_sep, is_ws, is_tab, emit_char, has_eor, ws_hold;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   assign is_break  = (req.char_in == CH_NL) || (req.char_in == CH_CR);
   assign is_cc     = (req.char_in == comment_char_ff);
   assign is_sep    = !in_comment_ff && (is_break || (req.char_in == CH_SEMI) || is_cc);
   assign is_tab    = (req.char_in == CH_TAB);
   assign is_ws     = is_tab || (req.char_in == CH_SPACE);
   assign emit_char = !in_comment_ff && !is_sep && !is_ws;
   assign ws_hold   = !in_comment_ff && !is_sep && is_ws && rhc_ff;

   // The final byte closes the row as though a separator followed it.
   assign has_eor = is_sep ? rhc_ff : (req.end_of_text && (rhc_ff || emit_char));

   assign q_push         = accept && (emit_char || has_eor);
   assign q_cmd.ws_count = emit_char ? pending_count_ff : '0;
   assign q_cmd.ws_tabs  = emit_char ? pending_tabs_ff : '0;
   assign q_cmd.has_char = emit_char;
   assign q_cmd.char_val = req.char_in;
   assign q_cmd.has_eor  = has_eor;
   assign q_cmd.ovf      = overflow_seen_ff;

   always_comb begin
      in_comment_in    = in_comment_ff;
      rhc_in           = rhc_ff;
      pending_count_in = pending_count_ff;
      pending_tabs_in  = pending_tabs_ff;
      overflow_seen_in = overflow_seen_ff;
      if (accept) begin
         if (in_comment_ff) begin
            in_comment_in = !is_break;
         end else if (is_sep) begin
            in_comment_in    = is_cc && !is_break;
            rhc_in           = 1'b0;
            pending_count_in = '0;
            pending_tabs_in  = '0;
            overflow_seen_in = 1'b0;
         end else if (emit_char) begin
            rhc_in           = 1'b1;
            pending_count_in = '0;
            pending_tabs_in  = '0;
            overflow_seen_in = 1'b0;
         end else if (ws_hold) begin
            if (pending_count_ff < WsMaxCount) begin
               pending_tabs_in[pending_count_ff[WsIdxWidth-1:0]] = is_tab;
               pending_count_in = CountWidth'(pending_count_ff + 1'b1);
            end else begin
               overflow_seen_in = 1'b1;
            end
         end
         if (req.end_of_text) begin
            in_comment_in    = 1'b0;
            rhc_in           = 1'b0;
            pending_count_in = '0;
            pending_tabs_in  = '0;
            overflow_seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_char_ff  <= CommentRst;
         in_comment_ff    <= 1'b0;
         rhc_ff           <= 1'b0;
         pending_count_ff <= '0;
         pending_tabs_ff  <= '0;
         overflow_seen_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            comment_char_ff <= csr_write_data;
         end
         in_comment_ff    <= in_comment_in;
         rhc_ff           <= rhc_in;
         pending_count_ff <= pending_count_in;
         pending_tabs_ff  <= pending_tabs_in;
         overflow_seen_ff <= overflow_seen_in;
      end
   end

   // Whitespace is only held inside a row that already has content.
   a_comment_clears_row: assert property (@(posedge clock) disable iff (reset)
      in_comment_ff |-> (!rhc_ff && pending_count_ff == '0))
      else $error("row state held while skipping a comment");

   a_overflow_only_when_full: assert property (@(posedge clock) disable iff (reset)
      overflow_seen_ff |-> (pending_count_ff == WsMaxCount))
      else $error("whitespace dropped before the buffer was full");

endmodule

// ===== rtl/ers_queue.sv =====
// Short command queue between the front end and the back end.
module ers_queue import ers_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ers_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        valid,
   output ers_cmd_type head
);

   ers_cmd_type             entry_ff [QueueDepth];
   logic [QPtrWidth-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QCountWidth-1:0]  count_ff, count_in;

   assign full  = (count_ff == QCountWidth'(QueueDepth));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = QCountWidth'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCountWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QPtrWidth'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= QPtrWidth'(rd_ptr_ff + 1'b1);
         end
         count_ff <= count_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("command pushed into a full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("command popped from an empty queue");

endmodule

// ===== rtl/ers_back.sv =====
// Back end: expands commands into result items through an output register.
module ers_back import ers_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  ers_cmd_type q_cmd,
   output logic        q_pop,
   ers_rsp_if.source   rsp
);

   logic [CountWidth-1:0]     ws_left_ff, ws_left_in;
   logic [PENDING_WS_MAX-1:0] tabs_ff, tabs_in;
   logic                      char_pend_ff, char_pend_in;
   logic [7:0]                char_ff, char_in;
   logic                      eor_pend_ff, eor_pend_in;
   logic                      ovf_ff, ovf_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       kind_ff, kind_in;
   logic       ws_ovf_ff, ws_ovf_in;
   logic       last_ff, last_in;

   logic out_free, active, advance, ws_zero, final_item;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign active     = (ws_left_ff != '0) || char_pend_ff || eor_pend_ff;
   assign advance    = active && out_free;
   assign ws_zero    = (ws_left_ff == '0);
   assign final_item = ws_zero && (!char_pend_ff || !eor_pend_ff);
   // The next command is taken in the same cycle as the last item of this one.
   assign q_pop      = q_valid && (!active || (advance && final_item));

   always_comb begin
      ws_left_in   = ws_left_ff;
      tabs_in      = tabs_ff;
      char_pend_in = char_pend_ff;
      char_in      = char_ff;
      eor_pend_in  = eor_pend_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      out_char_in  = out_char_ff;
      kind_in      = kind_ff;
      ws_ovf_in    = ws_ovf_ff;
      last_in      = last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (!ws_zero) begin
            out_char_in = tabs_ff[0] ? CH_TAB : CH_SPACE;
            kind_in     = 1'b0;
            ws_ovf_in   = ovf_ff;
            last_in     = 1'b0;
            tabs_in     = tabs_ff >> 1;
            ws_left_in  = CountWidth'(ws_left_ff - 1'b1);
         end else if (char_pend_ff) begin
            out_char_in  = char_ff;
            kind_in      = 1'b0;
            ws_ovf_in    = ovf_ff;
            last_in      = !eor_pend_ff;
            char_pend_in = 1'b0;
         end else begin
            out_char_in = 8'h00;
            kind_in     = 1'b1;
            ws_ovf_in   = 1'b0;
            last_in     = 1'b1;
            eor_pend_in = 1'b0;
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         ws_left_in   = q_cmd.ws_count;
         tabs_in      = q_cmd.ws_tabs;
         char_pend_in = q_cmd.has_char;
         char_in      = q_cmd.char_val;
         eor_pend_in  = q_cmd.has_eor;
         ovf_in       = q_cmd.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_left_ff   <= '0;
         char_pend_ff <= 1'b0;
         eor_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ws_left_ff   <= ws_left_in;
         char_pend_ff <= char_pend_in;
         eor_pend_ff  <= eor_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tabs_ff     <= tabs_in;
      char_ff     <= char_in;
      ovf_ff      <= ovf_in;
      out_char_ff <= out_char_in;
      kind_ff     <= kind_in;
      ws_ovf_ff   <= ws_ovf_in;
      last_ff     <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_char    = out_char_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.ws_overflow = ws_ovf_ff;
   assign rsp.last        = last_ff;

   a_eor_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff) |-> (last_ff && out_char_ff == 8'h00 && !ws_ovf_ff))
      else $error("end-of-row result is malformed");

   a_ws_needs_char: assert property (@(posedge clock) disable iff (reset)
      (ws_left_ff != '0) |-> char_pend_ff)
      else $error("held whitespace without a releasing character");

endmodule

// ===== rtl/expression_row_splitter.sv =====
// Top level of the expression row splitter: front end, command queue, back end.
//
//   Channel  Dir  Handshake        Content
//   req_bus  in   valid/ready      char_in, end_of_text
//   rsp_bus  out  valid/ready      out_char, kind, ws_overflow, last
//   csr_*    in   write enable     comment_char, 8 bits, no read-back
//
// A text byte is accepted every cycle while the four-entry command queue has
// room. Each byte that yields results holds the back end while they are issued
// one at a time as the output accepts them, up to 34 when held whitespace is
// released. Results leave through a registered output stage. Reset is
// synchronous and clears all control state; the comment byte returns to '#'.
module expression_row_splitter import ers_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ers_req_if.sink    req_bus,
   ers_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic        q_full, q_push, q_pop, q_valid;
   ers_cmd_type q_push_cmd, q_head;

   ers_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_bus),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_push_cmd)
   );

   ers_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   ers_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule
